// ===== hdl/timed_event_priority_queue_assert.svh =====
`ifndef TIMED_EVENT_PRIORITY_QUEUE_ASSERT_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_ASSERT_SVH
// assertion helpers
`ifndef ASSERT_OFF
`define TEPQ_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("tepq");
`define TEPQ_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("tepq");
`else
`define TEPQ_ASSERT_IMPL(label, a, c)
`define TEPQ_ASSERT_NEXT(label, a, c)
`endif
`endif

// ===== hdl/tepq_pkg.sv =====
package tepq_pkg;
  localparam int SEQ_BITS = 16;
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] event_time;
    logic signed [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic               out_valid;
    logic signed [31:0] out_time;
    logic signed [31:0] out_payload;
    logic               overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_START,
    ST_DN_LAST,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DN_CMP2,
    ST_TOP_RD,
    ST_TOP_CHK,
    ST_OUT
  } state_t;
endpackage

// ===== hdl/timed_event_priority_queue.sv =====
// Insert: an event that stays cached or is dropped goes straight to the output; else the
// event placed in the heap climbs one level per UP_RD/UP_CMP pass, stopping at or below the root.
// Dequeue: an event not yet due goes straight to the output; else heap tops are removed,
// each refilled by sifting the last entry down level by level with a final compare.
// One item at a time, no overlap; a heap pop is bounded by the sift loop over one
// single-read-port memory. Reset: cache empty, heap empty, sequence counter 0; heap
// memory is not cleared.
module timed_event_priority_queue #(
  parameter int HEAP_DEPTH = 256,
  parameter int TIME_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tepq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tepq_pkg::out_item_t  out_item
);
  import tepq_pkg::*;

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = TIME_BITS + SEQ_BITS;
  localparam int EW = KW + 32;

  state_t state, state_next;

  logic                        least_valid;
  logic signed [TIME_BITS-1:0] least_time;
  logic [31:0]                 least_payload;
  logic [SEQ_BITS-1:0]         least_seq;
  logic [CW-1:0]               heap_count;
  logic [SEQ_BITS-1:0]         seq_counter;

  logic [CW-1:0]  idx;
  logic [CW-1:0]  child;
  logic [KW-1:0]  cur_key;
  logic [31:0]    cur_pl;
  logic [EW-1:0]  c1;
  logic           promoted;
  out_item_t      res;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [EW-1:0]  mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [EW-1:0]  mem_rdata;

  tepq_mem #(.DEPTH(HEAP_DEPTH), .WIDTH(EW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  function automatic logic [KW-1:0] mk_key(logic signed [TIME_BITS-1:0] t,
                                           logic [SEQ_BITS-1:0] s);
    logic [TIME_BITS-1:0] b;
    b = t;
    b[TIME_BITS-1] = ~b[TIME_BITS-1];
    return {b, s};
  endfunction

  function automatic logic signed [TIME_BITS-1:0] key_t(logic [KW-1:0] k);
    logic [TIME_BITS-1:0] b;
    b = k[KW-1:SEQ_BITS];
    b[TIME_BITS-1] = ~b[TIME_BITS-1];
    return b;
  endfunction

  logic signed [TIME_BITS-1:0] in_t;
  assign in_t = TIME_BITS'(in_item.event_time);

  logic [KW-1:0] rd_key;
  logic [31:0]   rd_pl;
  logic [CW-1:0] parent;
  logic [CW:0]   c_left;
  logic signed [TIME_BITS-1:0] top_t;
  assign rd_key = mem_rdata[EW-1:32];
  assign rd_pl  = mem_rdata[31:0];
  assign parent = (idx - CW'(1)) >> 1;
  assign c_left = {idx, 1'b1};
  assign top_t  = key_t(rd_key);

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_item  = res;

  logic accept;
  assign accept = in_valid && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = idx[AW-1:0];
    mem_wdata  = {cur_key, cur_pl};
    mem_raddr  = parent[AW-1:0];
    case (state)
      ST_IDLE:    ;
      ST_UP_RD: begin
        if (idx == '0) begin
          mem_we = 1'b1;
          state_next = ST_OUT;
        end else begin
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (rd_key <= cur_key) begin
          mem_we = 1'b1;
          state_next = ST_OUT;
        end else begin
          mem_we = 1'b1;
          mem_wdata = mem_rdata;
          state_next = ST_UP_RD;
        end
      end
      ST_TOP_RD: begin
        mem_raddr = '0;
        state_next = (heap_count == '0) ? ST_OUT : ST_TOP_CHK;
      end
      ST_TOP_CHK: begin
        mem_raddr = AW'(heap_count - CW'(1));
        state_next = ST_DN_LAST;
      end
      ST_DN_LAST: begin
        mem_raddr = AW'(c_left);
        state_next = ST_DN_START;
      end
      ST_DN_START: begin
        if (CW'(c_left) >= heap_count || c_left[CW]) begin
          mem_we = 1'b1;
          state_next = promoted ? ST_OUT : ST_TOP_RD;
        end else begin
          mem_raddr = AW'(c_left + (CW+1)'(1));
          state_next = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        mem_raddr = AW'(c_left);
        state_next = ST_DN_CMP2;
      end
      ST_DN_CMP2: begin
        if (c1[EW-1:32] >= cur_key) begin
          mem_we = 1'b1;
          state_next = promoted ? ST_OUT : ST_TOP_RD;
        end else begin
          mem_we = 1'b1;
          mem_wdata = c1;
          state_next = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        mem_raddr = AW'(c_left);
        state_next = ST_DN_START;
      end
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (accept) begin
      state_next = ST_OUT;
      if (in_item.cmd == CMD_INSERT) begin
        if (least_valid && heap_count < CW'(HEAP_DEPTH)) state_next = ST_UP_RD;
      end else if (least_valid && least_time <= in_t) begin
        state_next = ST_TOP_RD;
      end
    end
  end

  // c1 holds the smaller child, compared in DN_CMP2
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      least_valid <= 1'b0;
      least_time  <= '0;
      least_payload <= '0;
      least_seq   <= '0;
      heap_count  <= '0;
      seq_counter <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_item.cmd == CMD_INSERT) begin
              if (!least_valid) begin
                res <= '0;
                least_valid <= 1'b1;
                least_time <= in_t;
                least_payload <= in_item.payload;
                least_seq <= seq_counter;
                seq_counter <= seq_counter + SEQ_BITS'(1);
              end else if (heap_count >= CW'(HEAP_DEPTH)) begin
                res <= '{out_valid: 1'b0, out_time: '0, out_payload: '0, overflow: 1'b1};
              end else begin
                res <= '0;
                idx <= heap_count;
                heap_count <= heap_count + CW'(1);
                seq_counter <= seq_counter + SEQ_BITS'(1);
                if (in_t < least_time) begin
                  cur_key <= mk_key(least_time, least_seq);
                  cur_pl <= least_payload;
                  least_time <= in_t;
                  least_payload <= in_item.payload;
                  least_seq <= seq_counter;
                end else begin
                  cur_key <= mk_key(in_t, seq_counter);
                  cur_pl <= in_item.payload;
                end
              end
            end else if (least_valid && least_time <= in_t) begin
              res <= '{out_valid: 1'b1, out_time: 32'(least_time),
                       out_payload: least_payload, overflow: 1'b0};
            end else begin
              res <= '0;
            end
          end
        end
        ST_UP_CMP: if (rd_key > cur_key) idx <= parent;
        ST_TOP_RD: begin
          if (heap_count == '0) begin
            least_valid <= 1'b0;
            least_time <= '0;
            least_payload <= '0;
            least_seq <= '0;
          end
        end
        ST_TOP_CHK: begin
          if (!top_t[TIME_BITS-1]) begin
            least_time <= top_t;
            least_payload <= rd_pl;
            least_seq <= rd_key[SEQ_BITS-1:0];
          end
          heap_count <= heap_count - CW'(1);
          idx <= '0;
          promoted <= !top_t[TIME_BITS-1];
        end
        ST_DN_LAST: begin
          cur_key <= rd_key;
          cur_pl <= rd_pl;
        end
        ST_DN_START: begin
          c1 <= mem_rdata;
        end
        ST_DN_CMP: begin
          if (CW'(c_left + (CW+1)'(1)) < heap_count
              && mem_rdata[EW-1:32] < c1[EW-1:32]) begin
            c1 <= mem_rdata;
            child <= CW'(c_left + (CW+1)'(1));
          end else begin
            child <= CW'(c_left);
          end
        end
        ST_DN_CMP2: begin
          if (c1[EW-1:32] < cur_key) idx <= child;
        end
        default: ;
      endcase
    end
  end

`include "timed_event_priority_queue_assert.svh"
  `TEPQ_ASSERT_IMPL(a_cnt, 1'b1, heap_count <= CW'(HEAP_DEPTH))
  `TEPQ_ASSERT_IMPL(a_ovf, out_valid, !(res.overflow && res.out_valid))
  `TEPQ_ASSERT_NEXT(a_stall, out_valid && out_stall, out_valid && $stable(res))
  `TEPQ_ASSERT_IMPL(a_empty, !least_valid && state == ST_IDLE, heap_count == '0)
endmodule

// ===== hdl/tepq_mem.sv =====
module tepq_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tepq_pkg::*;

  localparam int DEPTH = 256;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  timed_event_priority_queue u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // predictor state: cached earliest event plus min-heap of {biased time, seq}
  logic               cache_vld;
  logic signed [31:0] cache_time;
  logic signed [31:0] cache_pl;
  logic [15:0]        cache_seq;
  logic [15:0]        next_seq;
  logic [47:0]        hkey [DEPTH];
  logic [31:0]        hpl [DEPTH];
  int                 hcnt;

  out_item_t pending_results[$];
  int        errors;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles = 0;
  int        hold_reqs = 0;
  int        hold_seen = 0;

  function automatic logic [47:0] ev_key(logic signed [31:0] t, logic [15:0] s);
    return {t ^ 32'h8000_0000, s};
  endfunction

  function automatic logic signed [31:0] key_to_time(logic [47:0] k);
    return k[47:16] ^ 32'h8000_0000;
  endfunction

  function automatic void heap_insert(logic [47:0] k, logic [31:0] p);
    int i;
    int par;
    i = hcnt;
    hcnt++;
    while (i > 0) begin
      par = (i - 1) / 2;
      if (hkey[par] <= k) break;
      hkey[i] = hkey[par];
      hpl[i] = hpl[par];
      i = par;
    end
    hkey[i] = k;
    hpl[i] = p;
  endfunction

  function automatic void heap_remove_top();
    logic [47:0] lk;
    logic [31:0] lp;
    int i;
    int c;
    if (hcnt == 0) return;
    hcnt--;
    if (hcnt == 0) return;
    lk = hkey[hcnt];
    lp = hpl[hcnt];
    i = 0;
    forever begin
      c = 2 * i + 1;
      if (c >= hcnt) break;
      if (c + 1 < hcnt && hkey[c + 1] < hkey[c]) c++;
      if (hkey[c] >= lk) break;
      hkey[i] = hkey[c];
      hpl[i] = hpl[c];
      i = c;
    end
    hkey[i] = lk;
    hpl[i] = lp;
  endfunction

  function automatic out_item_t queue_step(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.cmd == CMD_INSERT) begin
      if (!cache_vld) begin
        cache_vld = 1'b1;
        cache_time = it.event_time;
        cache_pl = it.payload;
        cache_seq = next_seq;
        next_seq++;
      end else if (hcnt >= DEPTH) begin
        r.overflow = 1'b1;
      end else if (it.event_time < cache_time) begin
        heap_insert(ev_key(cache_time, cache_seq), cache_pl);
        cache_time = it.event_time;
        cache_pl = it.payload;
        cache_seq = next_seq;
        next_seq++;
      end else begin
        heap_insert(ev_key(it.event_time, next_seq), it.payload);
        next_seq++;
      end
    end else if (cache_vld && cache_time <= it.event_time) begin
      r.out_valid = 1'b1;
      r.out_time = cache_time;
      r.out_payload = cache_pl;
      while (hcnt > 0 && key_to_time(hkey[0]) < 0) heap_remove_top();
      if (hcnt > 0) begin
        cache_time = key_to_time(hkey[0]);
        cache_pl = hpl[0];
        cache_seq = hkey[0][15:0];
        heap_remove_top();
      end else begin
        cache_vld = 1'b0;
        cache_time = '0;
        cache_pl = '0;
        cache_seq = '0;
      end
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timed_event_priority_queue: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_item.out_time, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.out_valid !== want.out_valid)
          report_mismatch("out_valid", out_item.out_valid, want.out_valid);
        if (out_item.out_time !== want.out_time)
          report_mismatch("out_time", out_item.out_time, want.out_time);
        if (out_item.out_payload !== want.out_payload)
          report_mismatch("out_payload", out_item.out_payload, want.out_payload);
        if (out_item.overflow !== want.overflow)
          report_mismatch("overflow", out_item.overflow, want.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_cycles <= 400;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_item(logic c, logic signed [31:0] t, logic signed [31:0] p);
    in_item_t it;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    it.cmd = c;
    it.event_time = t;
    it.payload = p;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(queue_step(it));
  endtask

  task automatic drain_queue();
    while (cache_vld) send_item(CMD_DEQUEUE, 32'sh7fff_ffff, $urandom);
  endtask

  function automatic logic signed [31:0] rand_time();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(40)) - 20;
      2: return $signed($urandom_range(2000)) << 12;
      default: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  task automatic test_directed();
    send_item(CMD_DEQUEUE, 32'sh7fff_ffff, 0);
    send_item(CMD_INSERT, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(CMD_DEQUEUE, 32'sh7fff_fffe, 0);
    send_item(CMD_INSERT, 32'sh8000_0000, 32'sh8000_0000);
    send_item(CMD_INSERT, 32'sh0001_0000, 1);
    send_item(CMD_INSERT, 32'sh0001_0000, 2);
    send_item(CMD_INSERT, 32'sh0001_0000, 3);
    send_item(CMD_INSERT, -32'sh0000_0005, 4);
    send_item(CMD_INSERT, -32'sh0001_0000, 5);
    send_item(CMD_INSERT, 32'sh0000_0000, 6);
    send_item(CMD_DEQUEUE, 32'sh8000_0000, 0);
    send_item(CMD_DEQUEUE, 32'sh0000_0000, 0);
    send_item(CMD_DEQUEUE, 32'sh0000_ffff, 0);
    drain_queue();
    send_item(CMD_DEQUEUE, 32'sh7fff_ffff, 0);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 4; i++) send_item(CMD_INSERT, $urandom, $urandom);
    send_item(CMD_INSERT, 32'sh8000_0000, 7);
    drain_queue();
  endtask

  task automatic test_equal_times();
    for (int i = 0; i < 20; i++) begin
      send_item(CMD_INSERT, 32'sh0000_0100, i);
      send_item(CMD_INSERT, 32'sh0000_0100, ~i);
      send_item(CMD_DEQUEUE, 32'sh0000_0100, 0);
    end
    drain_queue();
  endtask

  task automatic test_random(int n, int sidle, int rstall);
    int target;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    target = $urandom_range(5, 120);
    for (int i = 0; i < n; i++) begin
      if (hcnt < target ? ($urandom_range(99) < 70) : ($urandom_range(99) < 30))
        send_item(CMD_INSERT, rand_time(), $urandom);
      else
        send_item(CMD_DEQUEUE, rand_time(), $urandom);
      if ($urandom_range(99) == 0) target = $urandom_range(5, 260);
    end
    drain_queue();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    for (int i = 0; i < 40; i++) send_item(1'($urandom_range(1)), rand_time(), $urandom);
    drain_queue();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cache_vld = 1'b0;
    cache_time = '0;
    cache_pl = '0;
    cache_seq = '0;
    next_seq = '0;
    hcnt = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_random(280, 0, 0);
    test_random(280, 71, 0);
    test_random(280, 0, 71);
    test_random(280, 22, 22);
    test_backpressure();
    test_equal_times();
    test_random(60, 22, 22);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("timed_event_priority_queue: match");
    end else begin
      $display("timed_event_priority_queue: mismatch");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tepq_pkg.sv
hdl/tepq_mem.sv
hdl/timed_event_priority_queue.sv
tb/tb_top.sv
